FILE: src/sacp_pkg.sv
// Shared types and constants for the short command APDU parser.
// Used by sacp_parse, sacp_out_stage and short_apdu_command_parser_top.
package sacp_pkg;

   localparam int COUNT_W   = 9;
   localparam int HDR_BYTES = 4;
   localparam int HDR_IDX_W = $clog2(HDR_BYTES);

   localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] POS_FIFTH  = COUNT_W'(HDR_BYTES);
   localparam logic [COUNT_W-1:0] DATA_START = COUNT_W'(HDR_BYTES + 1);
   localparam logic [COUNT_W-1:0] POS_LAST_SHORT = COUNT_W'(HDR_BYTES - 1);

   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TOO_SHORT = 2'd1;
   localparam logic [1:0] STATUS_BAD_LEN   = 2'd2;

   typedef struct packed {
      logic [7:0] data_in;
      logic       final_byte;
   } sacp_req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [7:0] cla;
      logic [7:0] ins;
      logic [7:0] param1;
      logic [7:0] param2;
      logic [7:0] lc_value;
      logic       lc_present;
      logic [7:0] le_value;
      logic       le_present;
      logic [1:0] status;
      logic       run_end;
   } sacp_rsp_type;

endpackage

FILE: src/sacp_parse.sv
// Input register, APDU parse state and result decode.
// Depends on sacp_pkg.
module sacp_parse import sacp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  sacp_req_type req_payload,
   output logic         res_valid,
   input  logic         res_ready,
   output sacp_rsp_type res_payload
);

   logic                 in_valid_ff;
   sacp_req_type         in_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   count_in;
   logic [7:0]           hdr_ff [HDR_BYTES];
   logic [7:0]           hdr_in [HDR_BYTES];
   logic [7:0]           hdr_cur [HDR_BYTES];
   logic [7:0]           fifth_ff;
   logic [7:0]           fifth_in;
   logic [7:0]           fifth_cur;
   logic [COUNT_W:0]     pos_ext;
   logic [COUNT_W:0]     lc_ext;
   logic                 is_data;
   logic                 advance;
   sacp_rsp_type         result;

   // The held byte leaves the input register whenever the result side can take
   // a transfer, whether or not the byte produces a result.
   assign advance   = in_valid_ff && res_ready;
   assign req_ready = !in_valid_ff || res_ready;
   assign res_valid = in_valid_ff && (in_ff.final_byte || is_data);
   assign res_payload = result;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_ff <= req_payload;
      end
   end

   always_comb begin
      for (int i = 0; i < HDR_BYTES; i++) begin
         hdr_cur[i] = (count_ff == COUNT_W'(i)) ? in_ff.data_in : hdr_ff[i];
      end
      fifth_cur = (count_ff == POS_FIFTH) ? in_ff.data_in : fifth_ff;
      pos_ext   = {1'b0, count_ff};
      lc_ext    = {{(COUNT_W - 7){1'b0}}, fifth_cur};
      is_data   = (count_ff >= DATA_START) && (pos_ext < lc_ext + (COUNT_W + 1)'(DATA_START));
   end

   always_comb begin
      result         = '0;
      result.run_end = 1'b1;
      if (!in_ff.final_byte) begin
         result.kind      = KIND_DATA;
         result.data_byte = in_ff.data_in;
      end else begin
         result.kind      = KIND_SUMMARY;
         result.data_byte = is_data ? in_ff.data_in : 8'd0;
         if (count_ff < POS_LAST_SHORT) begin
            result.status = STATUS_TOO_SHORT;
         end else begin
            result.cla    = hdr_cur[0];
            result.ins    = hdr_cur[1];
            result.param1 = hdr_cur[2];
            result.param2 = hdr_cur[3];
            if (count_ff == POS_LAST_SHORT) begin
               result.status = STATUS_OK;
            end else if (count_ff == POS_FIFTH) begin
               // A five-byte command carries Le alone.
               result.le_value   = fifth_cur;
               result.le_present = 1'b1;
               result.status     = STATUS_OK;
            end else if ((fifth_cur != 8'd0) &&
                         (pos_ext == lc_ext + (COUNT_W + 1)'(POS_FIFTH))) begin
               result.lc_value   = fifth_cur;
               result.lc_present = 1'b1;
               result.status     = STATUS_OK;
            end else if ((fifth_cur != 8'd0) &&
                         (pos_ext == lc_ext + (COUNT_W + 1)'(DATA_START))) begin
               // The byte after the data field is Le.
               result.lc_value   = fifth_cur;
               result.lc_present = 1'b1;
               result.le_value   = in_ff.data_in;
               result.le_present = 1'b1;
               result.status     = STATUS_OK;
            end else begin
               result.status = STATUS_BAD_LEN;
            end
         end
      end
   end

   always_comb begin
      if (in_ff.final_byte) begin
         count_in = '0;
         fifth_in = 8'd0;
         for (int i = 0; i < HDR_BYTES; i++) begin
            hdr_in[i] = 8'd0;
         end
      end else begin
         count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_W'(1);
         fifth_in = fifth_cur;
         for (int i = 0; i < HDR_BYTES; i++) begin
            hdr_in[i] = hdr_cur[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fifth_ff <= 8'd0;
         for (int i = 0; i < HDR_BYTES; i++) begin
            hdr_ff[i] <= 8'd0;
         end
      end else if (advance) begin
         count_ff <= count_in;
         fifth_ff <= fifth_in;
         for (int i = 0; i < HDR_BYTES; i++) begin
            hdr_ff[i] <= hdr_in[i];
         end
      end
   end

`ifndef SYNTHESIS
   a_final_clears_count: assert property (@(posedge clock) disable iff (reset)
      advance && in_ff.final_byte |=> count_ff == '0)
      else $error("byte count not cleared after the last byte");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      advance && !in_ff.final_byte && (count_ff != COUNT_MAX)
      |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("byte count did not advance by one");

   a_error_no_fields: assert property (@(posedge clock) disable iff (reset)
      res_valid && (result.status != STATUS_OK)
      |-> !result.lc_present && !result.le_present)
      else $error("length fields reported with an error status");

   a_data_in_window: assert property (@(posedge clock) disable iff (reset)
      res_valid && (result.kind == KIND_DATA) |-> count_ff >= DATA_START)
      else $error("data result emitted inside the header");
`endif

endmodule

FILE: src/sacp_out_stage.sv
// Result register that parts the parser from the result channel.
// Depends on sacp_pkg.
module sacp_out_stage import sacp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         res_valid,
   output logic         res_ready,
   input  sacp_rsp_type res_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output sacp_rsp_type rsp_payload
);

   logic         valid_ff;
   sacp_rsp_type data_ff;

   assign res_ready   = !valid_ff || rsp_ready;
   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (res_ready) begin
         valid_ff <= res_valid;
      end
      if (res_ready && res_valid) begin
         data_ff <= res_payload;
      end
   end

endmodule

FILE: src/short_apdu_command_parser_top.sv
// Top level of the short command APDU parser.
// Depends on sacp_pkg, sacp_parse and sacp_out_stage.
//
//   Channel  Direction  Payload         Transfer
//   req_     in         sacp_req_type   req_valid && req_ready
//   rsp_     out        sacp_rsp_type   rsp_valid && rsp_ready
//
// One byte is taken every cycle while the result channel does not stall.
// A result passes through the input register and the result register around the decode.
// Only data-field bytes and the last byte of each command produce a result.
// Reset is synchronous and clears both valid flags and the parse state.
// A stalled result channel holds the result register, then the input register.
module short_apdu_command_parser_top import sacp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  sacp_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output sacp_rsp_type rsp_payload
);

   logic         res_valid;
   logic         res_ready;
   sacp_rsp_type res_payload;

   sacp_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_payload (res_payload)
   );

   sacp_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_payload (res_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
